/* design/cia402_drive_state_with_position_profile_unit_defines.svh */
// assertion macros for the drive state and position profile block
`ifndef CIA402_DRIVE_STATE_WITH_POSITION_PROFILE_UNIT_DEFINES_SVH
`define CIA402_DRIVE_STATE_WITH_POSITION_PROFILE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define C402_CHK_IMPL(name, ck, rn, pre, post) \
  name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("c402pp check failed");

// next-cycle implication check
`define C402_CHK_NEXT(name, ck, rn, pre, post) \
  name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("c402pp check failed");

`else

`define C402_CHK_IMPL(name, ck, rn, pre, post)
`define C402_CHK_NEXT(name, ck, rn, pre, post)

`endif

`endif

/* design/c402pp_pkg.sv */
// shared types, codes and constants of the drive state and position profile block
package c402pp_pkg;

  localparam int TICK_MS_DEFAULT = 20;
  localparam int TICK_DEN        = 1000;

  localparam int VEL_W      = 24;
  localparam int POS_W      = 32;
  localparam int CW_W       = 16;
  localparam int MODE_W     = 8;
  localparam int FUNC_W     = 3;
  localparam int ST_W       = 3;

  // step = vel * TICK_MS / 1000 via reciprocal, exact for 24-bit velocity
  localparam int STEP_SHIFT = 34;
  localparam int RECIP_W    = 35;
  localparam int RECIP_LO_W = 18;
  localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
  localparam int PP_LO_W    = VEL_W + RECIP_LO_W;
  localparam int PP_HI_W    = VEL_W + RECIP_HI_W;
  localparam int PROD_W     = VEL_W + RECIP_W;

  // event codes
  localparam logic [FUNC_W-1:0] FN_INIT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CW    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MODE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESET = 3'd4;

  // drive states
  localparam logic [ST_W-1:0] ST_NOT_READY   = 3'd0;
  localparam logic [ST_W-1:0] ST_SOD         = 3'd1;
  localparam logic [ST_W-1:0] ST_READY       = 3'd2;
  localparam logic [ST_W-1:0] ST_SWITCHED_ON = 3'd3;
  localparam logic [ST_W-1:0] ST_OP_ENABLED  = 3'd4;
  localparam logic [ST_W-1:0] ST_QUICK_STOP  = 3'd5;
  localparam logic [ST_W-1:0] ST_FAULT_REACT = 3'd6;
  localparam logic [ST_W-1:0] ST_FAULT       = 3'd7;

  // controlword decode
  localparam logic [CW_W-1:0] CW_MASK_EV   = 16'h0002;
  localparam logic [CW_W-1:0] CW_MASK_QS   = 16'h0006;
  localparam logic [CW_W-1:0] CW_VAL_QS    = 16'h0002;
  localparam logic [CW_W-1:0] CW_MASK_SD   = 16'h0087;
  localparam logic [CW_W-1:0] CW_VAL_SD    = 16'h0006;
  localparam logic [CW_W-1:0] CW_MASK_ON   = 16'h008F;
  localparam logic [CW_W-1:0] CW_VAL_EN    = 16'h000F;
  localparam logic [CW_W-1:0] CW_VAL_SO    = 16'h0007;
  localparam int              CW_BIT_NSP   = 4;
  localparam int              CW_BIT_REL   = 6;
  localparam int              CW_BIT_FR    = 7;

  // statusword bits
  localparam logic [CW_W-1:0] SW_VOLTAGE   = 16'h0010;
  localparam logic [CW_W-1:0] SW_REACHED   = 16'h0400;
  localparam logic [CW_W-1:0] SW_ACK       = 16'h1000;

  localparam logic [MODE_W-1:0] MODE_PP    = 8'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CW_W-1:0]    cw;
    logic [POS_W-1:0]   tgt;
    logic [MODE_W-1:0]  mode;
    logic               vel_nz;
    logic [PP_LO_W-1:0] pp_lo;
    logic [PP_HI_W-1:0] pp_hi;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]   state;
    logic              ack;
    logic              reached;
    logic [POS_W-1:0]  pos;
    logic [MODE_W-1:0] mode;
  } drive_view_t;

endpackage

/* design/c402pp_in_stage.sv */
// input register with velocity-to-step partial products
module c402pp_in_stage
  import c402pp_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [CW_W-1:0]          in_control_word,
  input  logic signed [POS_W-1:0]  in_target_position,
  input  logic [VEL_W-1:0]         in_profile_velocity,
  input  logic signed [MODE_W-1:0] in_mode_request,
  input  logic                     fire,
  output logic                     s1_valid,
  output item_t                    item
);

  localparam logic [63:0] RECIP_FULL =
    ((64'(TICK_MS) << STEP_SHIFT) + 64'(TICK_DEN - 1)) / 64'(TICK_DEN);
  localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_FULL[RECIP_LO_W-1:0];
  localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_FULL[RECIP_W-1:RECIP_LO_W];

  logic  s1_valid_r, s1_valid_nxt;
  item_t item_r, item_nxt;
  logic  load;

  assign in_stall = s1_valid_r && !fire;
  assign load     = in_valid && !in_stall;

  always_comb begin
    item_nxt.func   = in_func;
    item_nxt.cw     = in_control_word;
    item_nxt.tgt    = in_target_position;
    item_nxt.mode   = in_mode_request;
    item_nxt.vel_nz = (in_profile_velocity != '0);
    item_nxt.pp_lo  = PP_LO_W'(in_profile_velocity) * PP_LO_W'(RECIP_LO);
    item_nxt.pp_hi  = PP_HI_W'(in_profile_velocity) * PP_HI_W'(RECIP_HI);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign item     = item_r;

endmodule

/* design/c402pp_core.sv */
// power state machine, setpoint handshake and motion stepping
module c402pp_core
  import c402pp_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  item_t       item,
  output drive_view_t view
);

`include "cia402_drive_state_with_position_profile_unit_defines.svh"

  logic [ST_W-1:0]   state_r, state_nxt;
  logic              moving_r, moving_nxt;
  logic              ack_r, ack_nxt;
  logic              reached_r, reached_nxt;
  logic              pfr_r, pfr_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  tgt_r, tgt_nxt;
  logic [VEL_W-1:0]  step_r, step_nxt;

  logic [PROD_W-1:0] prod;
  logic [VEL_W-1:0]  step_cand;
  logic              fr_edge;
  logic [ST_W-1:0]   nx;
  logic              new_sp;
  logic [POS_W:0]    rem;
  logic [POS_W:0]    mag;
  logic              close;
  logic              reset_ev;

  function automatic logic [ST_W-1:0] next_state(input logic [ST_W-1:0] cur,
                                                 input logic [CW_W-1:0] cw);
    logic [ST_W-1:0] r;
    r = cur;
    if ((cw & CW_MASK_EV) == '0) begin
      if (cur == ST_READY || cur == ST_SWITCHED_ON || cur == ST_OP_ENABLED ||
          cur == ST_QUICK_STOP) r = ST_SOD;
    end else if ((cw & CW_MASK_QS) == CW_VAL_QS) begin
      if (cur == ST_OP_ENABLED) r = ST_QUICK_STOP;
      else if (cur == ST_READY || cur == ST_SWITCHED_ON) r = ST_SOD;
    end else if ((cw & CW_MASK_SD) == CW_VAL_SD) begin
      if (cur == ST_SOD || cur == ST_SWITCHED_ON || cur == ST_OP_ENABLED) r = ST_READY;
    end else if ((cw & CW_MASK_ON) == CW_VAL_EN) begin
      if (cur == ST_SWITCHED_ON || cur == ST_QUICK_STOP || cur == ST_READY)
        r = ST_OP_ENABLED;
    end else if ((cw & CW_MASK_ON) == CW_VAL_SO) begin
      if (cur == ST_READY || cur == ST_OP_ENABLED) r = ST_SWITCHED_ON;
    end
    return r;
  endfunction

  // finish the reciprocal product: floor(vel * tick / 1000)
  assign prod      = {item.pp_hi, RECIP_LO_W'(0)} + PROD_W'(item.pp_lo);
  assign step_cand = prod[STEP_SHIFT+VEL_W-1:STEP_SHIFT];

  assign fr_edge = item.cw[CW_BIT_FR] && !pfr_r;
  assign nx      = next_state(state_r, item.cw);
  assign new_sp  = item.cw[CW_BIT_NSP];

  // exact signed distance, never overflows
  assign rem   = {tgt_r[POS_W-1], tgt_r} - {pos_r[POS_W-1], pos_r};
  assign mag   = rem[POS_W] ? (~rem + (POS_W+1)'(1)) : rem;
  assign close = (mag <= (POS_W+1)'(step_r)) || (step_r == '0);

  assign reset_ev = fire && (item.func == FN_RESET);

  always_comb begin
    state_nxt   = state_r;
    moving_nxt  = moving_r;
    ack_nxt     = ack_r;
    reached_nxt = reached_r;
    pfr_nxt     = pfr_r;
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    step_nxt    = step_r;
    case (item.func)
      FN_INIT: begin
        state_nxt  = ST_SOD;
        moving_nxt = 1'b0;
        ack_nxt    = 1'b0;
      end
      FN_CW: begin
        pfr_nxt = item.cw[CW_BIT_FR];
        if (fr_edge && state_r == ST_FAULT) begin
          state_nxt  = ST_SOD;
          moving_nxt = 1'b0;
          ack_nxt    = 1'b0;
        end else begin
          if (nx != state_r) begin
            state_nxt = nx;
            if (nx != ST_OP_ENABLED) begin
              moving_nxt = 1'b0;
              ack_nxt    = 1'b0;
            end
          end
          if (mode_r == MODE_PP && state_nxt == ST_OP_ENABLED) begin
            if (new_sp && !ack_nxt) begin
              tgt_nxt = item.cw[CW_BIT_REL] ? (item.tgt + pos_r) : item.tgt;
              if (item.vel_nz) begin
                step_nxt = step_cand;
              end
              ack_nxt     = 1'b1;
              moving_nxt  = 1'b1;
              reached_nxt = 1'b0;
            end else if (!new_sp && ack_nxt) begin
              ack_nxt = 1'b0;
            end
          end
        end
      end
      FN_MODE: begin
        mode_nxt = item.mode;
      end
      FN_TICK: begin
        if (moving_r) begin
          if (close) begin
            pos_nxt     = tgt_r;
            moving_nxt  = 1'b0;
            reached_nxt = 1'b1;
          end else if (!rem[POS_W]) begin
            pos_nxt = pos_r + POS_W'(step_r);
          end else begin
            pos_nxt = pos_r - POS_W'(step_r);
          end
        end
      end
      FN_RESET: begin
        state_nxt  = ST_NOT_READY;
        moving_nxt = 1'b0;
        ack_nxt    = 1'b0;
        pfr_nxt    = 1'b0;
        mode_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_NOT_READY;
      moving_r  <= 1'b0;
      ack_r     <= 1'b0;
      reached_r <= 1'b1;
      pfr_r     <= 1'b0;
      mode_r    <= '0;
      pos_r     <= '0;
      tgt_r     <= '0;
      step_r    <= VEL_W'(TICK_MS);
    end else if (fire) begin
      state_r   <= state_nxt;
      moving_r  <= moving_nxt;
      ack_r     <= ack_nxt;
      reached_r <= reached_nxt;
      pfr_r     <= pfr_nxt;
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      tgt_r     <= tgt_nxt;
      step_r    <= step_nxt;
    end
  end

  always_comb begin
    view.state   = state_nxt;
    view.ack     = ack_nxt;
    view.reached = reached_nxt;
    view.pos     = pos_nxt;
    view.mode    = mode_nxt;
  end

  `C402_CHK_IMPL(a_moving_only_enabled, clk, rst_n, moving_r, state_r == ST_OP_ENABLED)
  `C402_CHK_IMPL(a_ack_only_enabled, clk, rst_n, ack_r, state_r == ST_OP_ENABLED)
  `C402_CHK_IMPL(a_moving_not_reached, clk, rst_n, moving_r, !reached_r)
  `C402_CHK_NEXT(a_reset_event, clk, rst_n, reset_ev, state_r == ST_NOT_READY && mode_r == '0)

endmodule

/* design/c402pp_out_stage.sv */
// result register with statusword assembly
module c402pp_out_stage
  import c402pp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  drive_view_t              view,
  output logic                     out_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CW_W-1:0]          out_status_word,
  output logic signed [POS_W-1:0]  out_actual_position,
  output logic signed [MODE_W-1:0] out_mode_display
);

  logic              out_valid_r, out_valid_nxt;
  logic [CW_W-1:0]   sw_r, sw_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [MODE_W-1:0] mode_r;

  function automatic logic [CW_W-1:0] state_pattern(input logic [ST_W-1:0] s);
    logic [CW_W-1:0] p;
    case (s)
      ST_NOT_READY:   p = 16'h0000;
      ST_SOD:         p = 16'h0040;
      ST_READY:       p = 16'h0021;
      ST_SWITCHED_ON: p = 16'h0023;
      ST_OP_ENABLED:  p = 16'h0027;
      ST_QUICK_STOP:  p = 16'h0007;
      ST_FAULT_REACT: p = 16'h000F;
      ST_FAULT:       p = 16'h0008;
      default:        p = 16'h0000;
    endcase
    return p;
  endfunction

  always_comb begin
    sw_nxt = state_pattern(view.state);
    if (view.state == ST_OP_ENABLED || view.state == ST_SWITCHED_ON ||
        view.state == ST_QUICK_STOP) begin
      sw_nxt = sw_nxt | SW_VOLTAGE;
    end
    if (view.ack) begin
      sw_nxt = sw_nxt | SW_ACK;
    end
    if (view.reached) begin
      sw_nxt = sw_nxt | SW_REACHED;
    end
  end

  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sw_r   <= sw_nxt;
      pos_r  <= view.pos;
      mode_r <= view.mode;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status_word     = sw_r;
  assign out_actual_position = pos_r;
  assign out_mode_display    = mode_r;

endmodule

/* design/cia402_drive_state_with_position_profile_unit.sv */
// top level of the drive power state machine with profile-position stepping
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  func, control_word, target_position,
//                                         profile_velocity, mode_request
//  out_     output     out_valid/out_stall status_word, actual_position, mode_display
//
// one word in and one word out per cycle when neither side stalls
// each word passes the input register, then the state update into the result register
// the reciprocal step product is split across the input register and the update stage
// reset (rst_n low, synchronous) empties both registers and restores the drive state
// a stalled result holds its register; the input register still takes one more word
module cia402_drive_state_with_position_profile_unit
  import c402pp_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [CW_W-1:0]          in_control_word,
  input  logic signed [POS_W-1:0]  in_target_position,
  input  logic [VEL_W-1:0]         in_profile_velocity,
  input  logic signed [MODE_W-1:0] in_mode_request,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CW_W-1:0]          out_status_word,
  output logic signed [POS_W-1:0]  out_actual_position,
  output logic signed [MODE_W-1:0] out_mode_display
);

  // staged word, its valid, and the move into the result register
  item_t       item;
  logic        s1_valid;
  logic        out_ready;
  logic        fire;
  drive_view_t view;

  // a staged word moves on when the result register is free or being drained
  assign fire = s1_valid && out_ready;

  c402pp_in_stage #(
    .TICK_MS(TICK_MS)
  ) u_in (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_control_word    (in_control_word),
    .in_target_position (in_target_position),
    .in_profile_velocity(in_profile_velocity),
    .in_mode_request    (in_mode_request),
    .fire               (fire),
    .s1_valid           (s1_valid),
    .item               (item)
  );

  // drive state, setpoint handshake and position stepping
  c402pp_core #(
    .TICK_MS(TICK_MS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (item),
    .view (view)
  );

  // statusword assembly and result register
  c402pp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .view               (view),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status_word    (out_status_word),
    .out_actual_position(out_actual_position),
    .out_mode_display   (out_mode_display)
  );

endmodule
